/* hw/rtl/pmi_pkg.sv */
// ----------------------------------------------------------------------------
// pmi_pkg: shared types and constants of the pointer motion integrator
// Command codes, register indexes, speed limits and the words passed between
// the front end, the work queue and the back end.
// ----------------------------------------------------------------------------
package pmi_pkg;

	localparam int HISTORY_DEPTH = 4;
	localparam int SPEED_STEP    = 32;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_PRIME = 2'd2;

	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_JOY_LEFT      = 3'd2;
	localparam logic [2:0] REG_JOY_RIGHT     = 3'd3;
	localparam logic [2:0] REG_JOY_UP        = 3'd4;
	localparam logic [2:0] REG_JOY_DOWN      = 3'd5;
	localparam logic [2:0] REG_MOUSE_ENABLE  = 3'd6;
	localparam logic [2:0] REG_JOY_ENABLE    = 3'd7;

	localparam logic signed [23:0] SPEED_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SPEED_MIN = 24'sh800000;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_HOLD = 2'd2
	} op_kind_t;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic [15:0] up;
		logic [15:0] down;
		logic        mouse_en;
		logic        joy_en;
	} front_cfg_t;

	typedef struct packed {
		logic [12:0] width;
		logic [12:0] height;
	} back_cfg_t;

	typedef struct packed {
		op_kind_t           kind;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [2:0]  push_x;
		logic signed [2:0]  push_y;
		logic [3:0]         buttons;
	} work_t;

	typedef struct packed {
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [3:0]  buttons;
	} result_t;

endpackage

/* hw/rtl/pointer_motion_integrator.sv */
// ----------------------------------------------------------------------------
// pointer_motion_integrator: cursor integrator for mouse, joystick and keys
// A pushed word is held in the work queue, its result in the result queue.
// Throughput: one word per cycle unless the result side holds off popping;
// front and back end work combinationally; a two-entry queue follows each.
// Reset: cursor, velocities and joystick history clear; registers take their
// defaults; both queues empty.
// ----------------------------------------------------------------------------
module pointer_motion_integrator #(
	parameter int HISTORY_DEPTH = pmi_pkg::HISTORY_DEPTH,
	parameter int SPEED_STEP    = pmi_pkg::SPEED_STEP
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         command,
	input  logic signed [15:0] mouse_dx,
	input  logic signed [15:0] mouse_dy,
	input  logic [2:0]         mouse_buttons,
	input  logic [15:0]        joy_x,
	input  logic [15:0]        joy_y,
	input  logic [3:0]         joy_buttons,
	input  logic [5:0]         key_bits,
	input  logic signed [15:0] set_x,
	input  logic signed [15:0] set_y,
	output logic               empty,
	input  logic               pop,
	output logic [11:0]        pos_x,
	output logic [11:0]        pos_y,
	output logic [3:0]         buttons,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import pmi_pkg::*;

	front_cfg_t fcfg_q;
	back_cfg_t  bcfg_q;
	work_t      work_in;
	work_t      work_out;
	result_t    res_in;
	result_t    res_out;
	logic       take;
	logic       mid_empty;
	logic       out_full;
	logic       go;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;
	assign go        = !mid_empty && !out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcfg_q.width    <= 13'd320;
			bcfg_q.height   <= 13'd200;
			fcfg_q.left     <= 16'd16384;
			fcfg_q.right    <= 16'd49152;
			fcfg_q.up       <= 16'd16384;
			fcfg_q.down     <= 16'd49152;
			fcfg_q.mouse_en <= 1'b0;
			fcfg_q.joy_en   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  bcfg_q.width    <= cfg_data[12:0];
				REG_SCREEN_HEIGHT: bcfg_q.height   <= cfg_data[12:0];
				REG_JOY_LEFT:      fcfg_q.left     <= cfg_data;
				REG_JOY_RIGHT:     fcfg_q.right    <= cfg_data;
				REG_JOY_UP:        fcfg_q.up       <= cfg_data;
				REG_JOY_DOWN:      fcfg_q.down     <= cfg_data;
				REG_MOUSE_ENABLE:  fcfg_q.mouse_en <= cfg_data[0];
				REG_JOY_ENABLE:    fcfg_q.joy_en   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pmi_front #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.cfg          (fcfg_q),
		.command      (command),
		.mouse_dx     (mouse_dx),
		.mouse_dy     (mouse_dy),
		.mouse_buttons(mouse_buttons),
		.joy_x        (joy_x),
		.joy_y        (joy_y),
		.joy_buttons  (joy_buttons),
		.key_bits     (key_bits),
		.set_x        (set_x),
		.set_y        (set_y),
		.work         (work_in)
	);

	pmi_fifo #(
		.W($bits(work_t))
	) u_work_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (work_in),
		.pop   (go),
		.empty (mid_empty),
		.rdata (work_out)
	);

	pmi_back #(
		.SPEED_STEP(SPEED_STEP)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.cfg   (bcfg_q),
		.work  (work_out),
		.result(res_in)
	);

	pmi_fifo #(
		.W($bits(result_t))
	) u_result_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (go),
		.full  (out_full),
		.wdata (res_in),
		.pop   (pop),
		.empty (empty),
		.rdata (res_out)
	);

	assign pos_x   = res_out.pos_x;
	assign pos_y   = res_out.pos_y;
	assign buttons = res_out.buttons;

endmodule

/* hw/rtl/pmi_fifo.sv */
// ----------------------------------------------------------------------------
// pmi_fifo: two-entry word queue
// Decouples a producer from a consumer; a word may enter while the oldest
// one leaves in the same cycle.
// ----------------------------------------------------------------------------
module pmi_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* hw/rtl/pmi_front.sv */
// ----------------------------------------------------------------------------
// pmi_front: command decode and joystick history
// Classifies each word, keeps the joystick ring with running sums, compares
// the average against the limits and forms the pushes and merged buttons.
// ----------------------------------------------------------------------------
module pmi_front #(
	parameter int HISTORY_DEPTH = pmi_pkg::HISTORY_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  pmi_pkg::front_cfg_t cfg,
	input  logic [1:0]         command,
	input  logic signed [15:0] mouse_dx,
	input  logic signed [15:0] mouse_dy,
	input  logic [2:0]         mouse_buttons,
	input  logic [15:0]        joy_x,
	input  logic [15:0]        joy_y,
	input  logic [3:0]         joy_buttons,
	input  logic [5:0]         key_bits,
	input  logic signed [15:0] set_x,
	input  logic signed [15:0] set_y,
	output pmi_pkg::work_t     work
);
	import pmi_pkg::*;

	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SUM_W  = 16 + SLOT_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
	localparam logic [SUM_W-1:0]  DEPTH_K   = SUM_W'(HISTORY_DEPTH);

	logic [15:0]       hist_x_q [HISTORY_DEPTH];
	logic [15:0]       hist_y_q [HISTORY_DEPTH];
	logic [3:0]        hist_b_q [HISTORY_DEPTH];
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  sum_x_q;
	logic [SUM_W-1:0]  sum_y_q;

	logic [SUM_W-1:0]  sum_x_new;
	logic [SUM_W-1:0]  sum_y_new;
	logic [SUM_W-1:0]  lim_left;
	logic [SUM_W-1:0]  lim_right;
	logic [SUM_W-1:0]  lim_up;
	logic [SUM_W-1:0]  lim_down;
	logic [3:0]        joy_or;
	logic              is_tick;
	logic              is_prime;
	logic              joy_step;

	assign is_tick  = (command == CMD_TICK);
	assign is_prime = (command == CMD_PRIME);
	assign joy_step = take && is_tick && cfg.joy_en;

	// floor(sum / depth) < limit  <=>  sum < limit * depth
	assign sum_x_new = sum_x_q - SUM_W'(hist_x_q[slot_q]) + SUM_W'(joy_x);
	assign sum_y_new = sum_y_q - SUM_W'(hist_y_q[slot_q]) + SUM_W'(joy_y);
	assign lim_left  = SUM_W'(cfg.left) * DEPTH_K;
	assign lim_right = SUM_W'(cfg.right) * DEPTH_K;
	assign lim_up    = SUM_W'(cfg.up) * DEPTH_K;
	assign lim_down  = SUM_W'(cfg.down) * DEPTH_K;

	always_comb begin
		joy_or = 4'd0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			joy_or = joy_or | ((SLOT_W'(i) == slot_q) ? joy_buttons : hist_b_q[i]);
		end
	end

	always_comb begin
		work = '0;
		unique case (command)
			CMD_TICK: begin
				work.kind = OP_TICK;
				if (cfg.mouse_en) begin
					work.dx      = mouse_dx;
					work.dy      = mouse_dy;
					work.buttons = {1'b0, mouse_buttons};
				end
				if (cfg.joy_en) begin
					work.buttons = work.buttons | joy_or;
					if (sum_x_new < lim_left) work.push_x = work.push_x - 3'sd1;
					if (sum_x_new >= lim_right) work.push_x = work.push_x + 3'sd1;
					if (sum_y_new < lim_up) work.push_y = work.push_y - 3'sd1;
					if (sum_y_new >= lim_down) work.push_y = work.push_y + 3'sd1;
				end
				if (key_bits[0]) work.push_y = work.push_y - 3'sd1;
				if (key_bits[1]) work.push_y = work.push_y + 3'sd1;
				if (key_bits[2]) work.push_x = work.push_x - 3'sd1;
				if (key_bits[3]) work.push_x = work.push_x + 3'sd1;
				work.buttons = work.buttons | {2'b00, key_bits[5], key_bits[4]};
			end
			CMD_SET: begin
				work.kind = OP_SET;
				work.dx   = set_x;
				work.dy   = set_y;
			end
			default: begin
				work.kind = OP_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_x_q[i] <= '0;
				hist_y_q[i] <= '0;
				hist_b_q[i] <= '0;
			end
			slot_q  <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (joy_step) begin
			hist_x_q[slot_q] <= joy_x;
			hist_y_q[slot_q] <= joy_y;
			hist_b_q[slot_q] <= joy_buttons;
			sum_x_q          <= sum_x_new;
			sum_y_q          <= sum_y_new;
			slot_q           <= (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
		end else if (take && is_prime) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_x_q[i] <= joy_x;
				hist_y_q[i] <= joy_y;
				hist_b_q[i] <= '0;
			end
			slot_q  <= '0;
			sum_x_q <= SUM_W'(joy_x) * DEPTH_K;
			sum_y_q <= SUM_W'(joy_y) * DEPTH_K;
		end
	end

endmodule

/* hw/rtl/pmi_back.sv */
// ----------------------------------------------------------------------------
// pmi_back: velocity and cursor update
// Advances the saturating 16.8 velocities or zeroes them when nothing pushes,
// moves and clamps the cursor and forms one result word for each work word.
// ----------------------------------------------------------------------------
module pmi_back #(
	parameter int SPEED_STEP = pmi_pkg::SPEED_STEP
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  pmi_pkg::back_cfg_t cfg,
	input  pmi_pkg::work_t     work,
	output pmi_pkg::result_t   result
);
	import pmi_pkg::*;

	logic signed [23:0] speed_x_q;
	logic signed [23:0] speed_y_q;
	logic [11:0]        cur_x_q;
	logic [11:0]        cur_y_q;

	logic signed [23:0] speed_x_new;
	logic signed [23:0] speed_y_new;
	logic [11:0]        top_x;
	logic [11:0]        top_y;
	logic [11:0]        pos_x_new;
	logic [11:0]        pos_y_new;
	logic               is_tick;
	logic               moves;

	function automatic logic signed [23:0] advance(logic signed [23:0] v,
		logic signed [2:0] push);
		logic signed [10:0] delta;
		logic signed [24:0] s;
		delta = 11'(push) * 11'(SPEED_STEP);
		s     = 25'(v) + 25'(delta);
		if (push == 3'sd0) begin
			return '0;
		end else if (s > 25'(SPEED_MAX)) begin
			return SPEED_MAX;
		end else if (s < 25'(SPEED_MIN)) begin
			return SPEED_MIN;
		end
		return s[23:0];
	endfunction

	function automatic logic signed [15:0] whole(logic signed [23:0] v);
		logic signed [23:0] t;
		t = v[23] ? ((v + 24'sd255) >>> 8) : (v >>> 8);
		return t[15:0];
	endfunction

	function automatic logic [11:0] top_of(logic [12:0] size);
		if (size == 13'd0) begin
			return 12'd0;
		end else if (size > 13'd4096) begin
			return 12'hFFF;
		end
		return 12'(size - 13'd1);
	endfunction

	function automatic logic [11:0] place(logic [11:0] cur, logic tick,
		logic signed [15:0] d, logic signed [15:0] sp, logic [11:0] top);
		logic signed [18:0] p;
		p = (tick ? $signed({7'b0, cur}) : 19'sd0) + 19'(d) + (tick ? 19'(sp) : 19'sd0);
		if (p[18]) begin
			return 12'd0;
		end else if (p > $signed({7'b0, top})) begin
			return top;
		end
		return p[11:0];
	endfunction

	assign is_tick     = (work.kind == OP_TICK);
	assign moves       = is_tick || (work.kind == OP_SET);
	assign speed_x_new = advance(speed_x_q, work.push_x);
	assign speed_y_new = advance(speed_y_q, work.push_y);
	assign top_x       = top_of(cfg.width);
	assign top_y       = top_of(cfg.height);
	assign pos_x_new   = place(cur_x_q, is_tick, work.dx, whole(speed_x_new), top_x);
	assign pos_y_new   = place(cur_y_q, is_tick, work.dy, whole(speed_y_new), top_y);

	assign result.pos_x   = moves ? pos_x_new : cur_x_q;
	assign result.pos_y   = moves ? pos_y_new : cur_y_q;
	assign result.buttons = work.buttons;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_x_q <= '0;
			speed_y_q <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
		end else if (go) begin
			if (is_tick) begin
				speed_x_q <= speed_x_new;
				speed_y_q <= speed_y_new;
			end
			if (moves) begin
				cur_x_q <= pos_x_new;
				cur_y_q <= pos_y_new;
			end
		end
	end

endmodule

/* bench/tb_pointer_motion_integrator.sv */
// ----------------------------------------------------------------------------
// tb_pointer_motion_integrator: self-checking bench for the cursor integrator
// Drives frame ticks, set and prime commands (and the unused command code)
// through the push/full side, checks every word popped from the result side
// against a cycle-free model of cursor, velocity and joystick history, and
// walks the registers through several settings, extremes included. Both
// sides idle in random bursts; one stretch holds the result side off until
// the block stalls its input, and one unbroken run ramps both velocities up
// with held keys, clears them with a keyless tick and then reverses the keys.
// ----------------------------------------------------------------------------
module tb_pointer_motion_integrator;

	import pmi_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	localparam int KEY_UP     = 0;
	localparam int KEY_DOWN   = 1;
	localparam int KEY_LEFT   = 2;
	localparam int KEY_RIGHT  = 3;
	localparam int KEY_SELECT = 4;
	localparam int KEY_ESCAPE = 5;

	localparam int BTN_SELECT = 0;
	localparam int BTN_ESCAPE = 1;

	localparam int RAMP_TICKS = 40;

	typedef struct {
		logic [1:0]         command;
		logic signed [15:0] mouse_dx;
		logic signed [15:0] mouse_dy;
		logic [2:0]         mouse_buttons;
		logic [15:0]        joy_x;
		logic [15:0]        joy_y;
		logic [3:0]         joy_buttons;
		logic [5:0]         key_bits;
		logic signed [15:0] set_x;
		logic signed [15:0] set_y;
	} motion_word_t;

	typedef struct {
		logic [2:0]  index;
		logic [15:0] data;
	} reg_write_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [1:0]         command = '0;
	logic signed [15:0] mouse_dx = '0;
	logic signed [15:0] mouse_dy = '0;
	logic [2:0]         mouse_buttons = '0;
	logic [15:0]        joy_x = '0;
	logic [15:0]        joy_y = '0;
	logic [3:0]         joy_buttons = '0;
	logic [5:0]         key_bits = '0;
	logic signed [15:0] set_x = '0;
	logic signed [15:0] set_y = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [11:0]        pos_x;
	logic [11:0]        pos_y;
	logic [3:0]         buttons;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	// model state
	logic [11:0]        cur_x = '0;
	logic [11:0]        cur_y = '0;
	logic signed [23:0] vel_x = '0;
	logic signed [23:0] vel_y = '0;
	logic [15:0]        hist_x [HISTORY_DEPTH];
	logic [15:0]        hist_y [HISTORY_DEPTH];
	logic [3:0]         hist_btn [HISTORY_DEPTH];
	int                 next_slot = 0;

	// register copies
	logic [12:0] scr_width = 13'd320;
	logic [12:0] scr_height = 13'd200;
	logic [15:0] lim_left = 16'd16384;
	logic [15:0] lim_right = 16'd49152;
	logic [15:0] lim_up = 16'd16384;
	logic [15:0] lim_down = 16'd49152;
	logic        mouse_on = 1'b0;
	logic        joy_on = 1'b0;

	result_t    pending_results [$];
	reg_write_t reg_writes [$];
	int         fail_count = 0;
	int         results_seen = 0;
	int         stall_req = 0;
	int         hold_left = 0;
	bit         idle_on = 1'b1;

	pointer_motion_integrator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.mouse_dx     (mouse_dx),
		.mouse_dy     (mouse_dy),
		.mouse_buttons(mouse_buttons),
		.joy_x        (joy_x),
		.joy_y        (joy_y),
		.joy_buttons  (joy_buttons),
		.key_bits     (key_bits),
		.set_x        (set_x),
		.set_y        (set_y),
		.empty        (empty),
		.pop          (pop),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.buttons      (buttons),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			hist_x[i] = '0;
			hist_y[i] = '0;
			hist_btn[i] = '0;
		end
	end

	function automatic logic [11:0] clamp_axis(input int p, input logic [12:0] size);
		int top;
		top = int'(size) - 1;
		if (size == 0)
			top = 0;
		if (size > 13'd4096)
			top = 4095;
		if (p < 0)
			p = 0;
		if (p > top)
			p = top;
		return 12'(p);
	endfunction

	function automatic logic signed [23:0] step_speed(input logic signed [23:0] v,
			input int push_amt);
		int s;
		s = (push_amt == 0) ? 0 : int'(v);
		s = s + push_amt;
		if (s > int'(SPEED_MAX))
			s = int'(SPEED_MAX);
		if (s < int'(SPEED_MIN))
			s = int'(SPEED_MIN);
		return 24'(s);
	endfunction

	function automatic result_t integrate_word(input motion_word_t w);
		result_t    r;
		int         nx;
		int         ny;
		int         px;
		int         py;
		int         sx;
		int         sy;
		logic [3:0] jb;
		logic [3:0] btn;
		nx = int'(cur_x);
		ny = int'(cur_y);
		px = 0;
		py = 0;
		btn = '0;
		if (w.command == CMD_TICK) begin
			if (mouse_on) begin
				nx += int'(w.mouse_dx);
				ny += int'(w.mouse_dy);
				btn |= {1'b0, w.mouse_buttons};
			end
			if (joy_on) begin
				hist_x[next_slot] = w.joy_x;
				hist_y[next_slot] = w.joy_y;
				hist_btn[next_slot] = w.joy_buttons;
				next_slot = (next_slot + 1) % HISTORY_DEPTH;
				sx = 0;
				sy = 0;
				jb = '0;
				for (int i = 0; i < HISTORY_DEPTH; i++) begin
					sx += int'(hist_x[i]);
					sy += int'(hist_y[i]);
					jb |= hist_btn[i];
				end
				sx = sx / HISTORY_DEPTH;
				sy = sy / HISTORY_DEPTH;
				if (sx < int'(lim_left))
					px -= SPEED_STEP;
				if (sx >= int'(lim_right))
					px += SPEED_STEP;
				if (sy < int'(lim_up))
					py -= SPEED_STEP;
				if (sy >= int'(lim_down))
					py += SPEED_STEP;
				btn |= jb;
			end
			if (w.key_bits[KEY_UP])
				py -= SPEED_STEP;
			if (w.key_bits[KEY_DOWN])
				py += SPEED_STEP;
			if (w.key_bits[KEY_LEFT])
				px -= SPEED_STEP;
			if (w.key_bits[KEY_RIGHT])
				px += SPEED_STEP;
			if (w.key_bits[KEY_SELECT])
				btn[BTN_SELECT] = 1'b1;
			if (w.key_bits[KEY_ESCAPE])
				btn[BTN_ESCAPE] = 1'b1;
			vel_x = step_speed(vel_x, px);
			vel_y = step_speed(vel_y, py);
			nx += int'(vel_x) / 256;
			ny += int'(vel_y) / 256;
			cur_x = clamp_axis(nx, scr_width);
			cur_y = clamp_axis(ny, scr_height);
		end else if (w.command == CMD_SET) begin
			cur_x = clamp_axis(int'(w.set_x), scr_width);
			cur_y = clamp_axis(int'(w.set_y), scr_height);
		end else if (w.command == CMD_PRIME) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_x[i] = w.joy_x;
				hist_y[i] = w.joy_y;
				hist_btn[i] = '0;
			end
			next_slot = 0;
		end
		r.pos_x = cur_x;
		r.pos_y = cur_y;
		r.buttons = btn;
		return r;
	endfunction

	function automatic void store_setting(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			REG_SCREEN_WIDTH:  scr_width = data[12:0];
			REG_SCREEN_HEIGHT: scr_height = data[12:0];
			REG_JOY_LEFT:      lim_left = data;
			REG_JOY_RIGHT:     lim_right = data;
			REG_JOY_UP:        lim_up = data;
			REG_JOY_DOWN:      lim_down = data;
			REG_MOUSE_ENABLE:  mouse_on = data[0];
			REG_JOY_ENABLE:    joy_on = data[0];
			default: ;
		endcase
	endfunction

	function automatic void queue_write(input logic [2:0] idx, input logic [15:0] data);
		reg_write_t rw;
		rw.index = idx;
		rw.data = data;
		reg_writes.push_back(rw);
	endfunction

	function automatic motion_word_t blank_word(input logic [1:0] cmd);
		motion_word_t w;
		w = '{default: '0};
		w.command = cmd;
		return w;
	endfunction

	function automatic motion_word_t noise_word(input logic [1:0] cmd);
		motion_word_t w;
		w.command = cmd;
		w.mouse_dx = 16'($urandom);
		w.mouse_dy = 16'($urandom);
		w.mouse_buttons = 3'($urandom);
		w.joy_x = 16'($urandom);
		w.joy_y = 16'($urandom);
		w.joy_buttons = 4'($urandom);
		w.key_bits = 6'($urandom);
		w.set_x = 16'($urandom);
		w.set_y = 16'($urandom);
		return w;
	endfunction

	function automatic logic [15:0] joy_level();
		case ($urandom_range(0, 3))
			0:       return 16'($urandom_range(0, 16383));
			1:       return 16'($urandom_range(16384, 49151));
			2:       return 16'($urandom_range(49152, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_size();
		case ($urandom_range(0, 5))
			0:       return 16'd1;
			1:       return 16'd4096;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(2, 640));
		endcase
	endfunction

	function automatic void queue_limits(input logic [2:0] lo_idx, input logic [2:0] hi_idx);
		logic [15:0] a;
		logic [15:0] b;
		case ($urandom_range(0, 4))
			0: begin
				a = 16'd16384;
				b = 16'd49152;
			end
			1: begin
				a = 16'($urandom_range(0, 32767));
				b = 16'($urandom_range(32768, 65535));
			end
			2: begin
				a = 16'($urandom_range(32768, 65535));
				b = 16'($urandom_range(0, 32767));
			end
			3: begin
				a = 16'd0;
				b = 16'hFFFF;
			end
			default: begin
				a = 16'($urandom);
				b = 16'($urandom);
			end
		endcase
		queue_write(lo_idx, a);
		queue_write(hi_idx, b);
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("mismatch at word %0d: %s", results_seen, msg);
	endtask

	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("word %0d/%0d/%0d with none pending",
				pos_x, pos_y, buttons));
			return;
		end
		want = pending_results.pop_front();
		if (pos_x !== want.pos_x)
			report_mismatch($sformatf("pos_x %0d, expected %0d", pos_x, want.pos_x));
		if (pos_y !== want.pos_y)
			report_mismatch($sformatf("pos_y %0d, expected %0d", pos_y, want.pos_y));
		if (buttons !== want.buttons)
			report_mismatch($sformatf("buttons %h, expected %h", buttons, want.buttons));
		results_seen++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_result();
			if (stall_req != 0) begin
				hold_left = stall_req;
				stall_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(1, 5) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic send_word(input motion_word_t w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		push <= 1'b1;
		command <= w.command;
		mouse_dx <= w.mouse_dx;
		mouse_dy <= w.mouse_dy;
		mouse_buttons <= w.mouse_buttons;
		joy_x <= w.joy_x;
		joy_y <= w.joy_y;
		joy_buttons <= w.joy_buttons;
		key_bits <= w.key_bits;
		set_x <= w.set_x;
		set_y <= w.set_y;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_results.push_back(integrate_word(w));
	endtask

	task automatic wait_for_results();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic apply_settings();
		reg_write_t rw;
		wait_for_results();
		while (reg_writes.size() != 0) begin
			rw = reg_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= rw.index;
			cfg_data <= rw.data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			store_setting(rw.index, rw.data);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count);
		motion_word_t w;
		logic [5:0]   held_keys;
		logic [15:0]  aim_x;
		logic [15:0]  aim_y;
		int           stretch;
		int           pick;
		stretch = 0;
		held_keys = '0;
		aim_x = '0;
		aim_y = '0;
		repeat (count) begin
			if (stretch == 0) begin
				stretch = $urandom_range(1, 40);
				held_keys = 6'($urandom);
				aim_x = joy_level();
				aim_y = joy_level();
			end
			stretch--;
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				w = noise_word(CMD_TICK);
				if ($urandom_range(0, 9) != 0)
					w.key_bits = held_keys;
				if ($urandom_range(0, 9) != 0) begin
					w.mouse_dx = 16'($urandom_range(0, 32)) - 16'd16;
					w.mouse_dy = 16'($urandom_range(0, 32)) - 16'd16;
				end
				if ($urandom_range(0, 7) != 0) begin
					w.joy_x = aim_x + 16'($urandom_range(0, 1023));
					w.joy_y = aim_y + 16'($urandom_range(0, 1023));
				end
			end else if (pick < 88) begin
				w = noise_word(CMD_SET);
				if ($urandom_range(0, 1) != 0) begin
					w.set_x = 16'($urandom_range(0, 4200));
					w.set_y = 16'($urandom_range(0, 4200));
				end
			end else if (pick < 96) begin
				w = noise_word(CMD_PRIME);
				if ($urandom_range(0, 1) != 0) begin
					w.joy_x = aim_x;
					w.joy_y = aim_y;
				end
			end else begin
				w = noise_word(CMD_UNKNOWN);
			end
			send_word(w);
		end
	endtask

	task automatic random_settings();
		queue_write(REG_SCREEN_WIDTH, pick_size());
		queue_write(REG_SCREEN_HEIGHT, pick_size());
		queue_limits(REG_JOY_LEFT, REG_JOY_RIGHT);
		queue_limits(REG_JOY_UP, REG_JOY_DOWN);
		queue_write(REG_MOUSE_ENABLE, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
		queue_write(REG_JOY_ENABLE, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
		apply_settings();
	endtask

	task automatic test_defaults();
		motion_word_t w;
		w = blank_word(CMD_TICK);
		w.mouse_dx = 16'sh7FFF;
		w.mouse_dy = -16'sh8000;
		w.mouse_buttons = 3'b111;
		send_word(w);
		w = blank_word(CMD_SET);
		w.set_x = -16'sh8000;
		w.set_y = 16'sh7FFF;
		send_word(w);
		w.set_x = 16'sh7FFF;
		w.set_y = -16'sh8000;
		send_word(w);
		w.set_x = 16'sd160;
		w.set_y = 16'sd100;
		send_word(w);
		w = blank_word(CMD_TICK);
		w.key_bits[KEY_RIGHT] = 1'b1;
		w.key_bits[KEY_DOWN] = 1'b1;
		w.key_bits[KEY_SELECT] = 1'b1;
		w.key_bits[KEY_ESCAPE] = 1'b1;
		send_word(w);
		w.key_bits = 6'h3F;
		send_word(w);
		w = blank_word(CMD_UNKNOWN);
		w.mouse_dx = 16'hFFFF;
		w.joy_x = 16'hFFFF;
		w.key_bits = 6'h3F;
		w.set_x = 16'hFFFF;
		send_word(w);
		w = blank_word(CMD_PRIME);
		w.joy_x = 16'hFFFF;
		send_word(w);
	endtask

	task automatic test_devices();
		motion_word_t w;
		queue_write(REG_SCREEN_WIDTH, 16'd4096);
		queue_write(REG_SCREEN_HEIGHT, 16'd4096);
		queue_write(REG_JOY_LEFT, 16'd16384);
		queue_write(REG_JOY_RIGHT, 16'd49152);
		queue_write(REG_JOY_UP, 16'd16384);
		queue_write(REG_JOY_DOWN, 16'd49152);
		queue_write(REG_MOUSE_ENABLE, 16'd1);
		queue_write(REG_JOY_ENABLE, 16'd1);
		apply_settings();
		w = blank_word(CMD_SET);
		w.set_x = 16'sd2048;
		w.set_y = 16'sd2048;
		send_word(w);
		w = blank_word(CMD_TICK);
		w.mouse_dx = 16'sh7FFF;
		w.mouse_dy = -16'sh8000;
		w.mouse_buttons = 3'b111;
		w.joy_x = 16'hFFFF;
		w.joy_buttons = 4'hF;
		send_word(w);
		w.mouse_dx = -16'sh8000;
		w.mouse_dy = 16'sh7FFF;
		w.mouse_buttons = 3'b000;
		w.joy_x = 16'h0000;
		w.joy_y = 16'hFFFF;
		w.joy_buttons = 4'h0;
		send_word(w);
		w = blank_word(CMD_PRIME);
		w.joy_y = 16'hFFFF;
		send_word(w);
		w = blank_word(CMD_TICK);
		w.joy_y = 16'hFFFF;
		send_word(w);
	endtask

	task automatic test_crossed_limits();
		motion_word_t w;
		queue_write(REG_SCREEN_WIDTH, 16'd0);
		queue_write(REG_SCREEN_HEIGHT, 16'hFFFF);
		queue_write(REG_JOY_LEFT, 16'hFFFF);
		queue_write(REG_JOY_RIGHT, 16'd0);
		queue_write(REG_JOY_UP, 16'hFFFF);
		queue_write(REG_JOY_DOWN, 16'd0);
		apply_settings();
		w = blank_word(CMD_TICK);
		w.joy_x = 16'h8000;
		w.joy_y = 16'h8000;
		send_word(w);
		w = blank_word(CMD_SET);
		w.set_x = 16'sd4095;
		w.set_y = 16'sd5000;
		send_word(w);
		w = blank_word(CMD_TICK);
		w.key_bits[KEY_LEFT] = 1'b1;
		send_word(w);
		queue_write(REG_JOY_LEFT, 16'd0);
		queue_write(REG_JOY_RIGHT, 16'hFFFF);
		queue_write(REG_JOY_UP, 16'd0);
		queue_write(REG_JOY_DOWN, 16'hFFFF);
		apply_settings();
		w = blank_word(CMD_PRIME);
		w.joy_x = 16'hFFFF;
		w.joy_y = 16'hFFFF;
		send_word(w);
		w = blank_word(CMD_TICK);
		w.joy_x = 16'hFFFF;
		w.joy_y = 16'hFFFF;
		send_word(w);
	endtask

	task automatic test_backpressure();
		random_settings();
		stall_req = 60;
		run_random(30);
		wait_for_results();
	endtask

	task automatic test_random_settings();
		repeat (7) begin
			random_settings();
			run_random(180);
		end
	endtask

	task automatic test_speed_ramp();
		motion_word_t w;
		idle_on = 1'b0;
		queue_write(REG_SCREEN_WIDTH, 16'd4096);
		queue_write(REG_SCREEN_HEIGHT, 16'd4096);
		queue_write(REG_MOUSE_ENABLE, 16'd0);
		queue_write(REG_JOY_ENABLE, 16'd0);
		apply_settings();
		repeat (RAMP_TICKS) begin
			w = noise_word(CMD_TICK);
			w.key_bits = '0;
			w.key_bits[KEY_RIGHT] = 1'b1;
			w.key_bits[KEY_UP] = 1'b1;
			send_word(w);
		end
		w = blank_word(CMD_TICK);
		send_word(w);
		w.key_bits[KEY_LEFT] = 1'b1;
		w.key_bits[KEY_DOWN] = 1'b1;
		repeat (3) send_word(w);
	endtask

	task automatic test_settled_run();
		random_settings();
		run_random(200);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_defaults();
		test_devices();
		test_crossed_limits();
		test_backpressure();
		test_random_settings();
		test_speed_ramp();
		test_settled_run();
		wait_for_results();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#40000000;
		$display("timeout with %0d words pending", pending_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
